@@ src/assert_macros.svh @@
// assertion macros shared by the checker files
// needs clock and reset in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset only
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALL(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ src/fh64_pkg.sv @@
// fasthash64 stream package: constants, queue word type, sequencer states
// and mixing helpers; no dependencies
`timescale 1ns / 1ps

package fh64_pkg;

   localparam logic [63:0] HASH_MUL   = 64'h880355f21e6d1965;
   localparam logic [63:0] MIX_MUL    = 64'h2127599bf4325c37;
   localparam logic [63:0] SEED_RESET = 64'h00000000A16231A7;
   localparam int SHIFT_A = 23;
   localparam int SHIFT_B = 47;

   localparam int LEN_BITS  = 16;
   localparam int NB_W      = 4;
   localparam int WORD_BYTES = 8;

   localparam int ADDR_W = 3;
   localparam logic [ADDR_W-1:0] ADDR_HASH_SEED = 3'd0;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   typedef struct packed {
      logic                first;
      logic                last;
      logic                has_data;
      logic [63:0]         data;
      logic [LEN_BITS-1:0] len;
   } cmd_type;

   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
   } mul_req_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SEED,
      ST_MIX,
      ST_FOLD,
      ST_FINAL,
      ST_OUT
   } back_state_type;

   function automatic logic [63:0] xs_a(input logic [63:0] x);
      xs_a = x ^ (x >> SHIFT_A);
   endfunction

   function automatic logic [63:0] xs_b(input logic [63:0] x);
      xs_b = x ^ (x >> SHIFT_B);
   endfunction

endpackage

@@ src/fh64_mul.sv @@
// shared 64x64 multiplier, low 64 bits of the product, three 32x32 partial
// products, one per cycle; uses fh64_pkg
`timescale 1ns / 1ps

module fh64_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  fh64_pkg::mul_req_type mul_req,
   output logic                 mul_done,
   output logic [63:0]          mul_p
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [1:0]  step_ff, step_in;
   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] op_a, op_b;
   logic [63:0] prod;

   always_comb begin
      if (step_ff == 2'd0) begin
         op_a = a_ff[31:0];
         op_b = b_ff[31:0];
      end else if (step_ff == 2'd1) begin
         op_a = a_ff[31:0];
         op_b = b_ff[63:32];
      end else begin
         op_a = a_ff[63:32];
         op_b = b_ff[31:0];
      end
   end

   assign prod = {32'h0, op_a} * {32'h0, op_b};

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      done_in = 1'b0;
      if (mul_req.start) begin
         a_in    = mul_req.a;
         b_in    = mul_req.b;
         busy_in = 1'b1;
         step_in = 2'd0;
      end else if (busy_ff) begin
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd0) begin
            acc_in = prod;
         end else begin
            // cross terms only reach the upper half
            acc_in = acc_ff + {prod[31:0], 32'h0};
         end
         if (step_ff == 2'd2) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign mul_done = done_ff;
   assign mul_p    = acc_ff;

endmodule

@@ src/fh64_front.sv @@
// front end: takes input words, masks the tail bytes, tracks whether a
// message is open and drops stray words; uses fh64_pkg
`timescale 1ns / 1ps

module fh64_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [63:0]                   req_word_data,
   input  logic [fh64_pkg::NB_W-1:0]     req_valid_bytes,
   input  logic                          req_first_word,
   input  logic                          req_last_word,
   input  logic [15:0]                   req_total_length,
   input  logic                          q_full,
   output logic                          q_push,
   output fh64_pkg::cmd_type             q_wdata
);

   logic                      in_msg_ff, in_msg_in;
   logic                      accept;
   logic                      live;
   logic [fh64_pkg::NB_W-1:0] nb;
   logic [63:0]               data_m;

   assign req_stall = q_full;
   assign accept    = req_valid & ~q_full;
   assign live      = req_first_word | in_msg_ff;

   always_comb begin
      nb = (req_valid_bytes > fh64_pkg::NB_W'(fh64_pkg::WORD_BYTES)) ?
           fh64_pkg::NB_W'(fh64_pkg::WORD_BYTES) : req_valid_bytes;
      for (int i = 0; i < fh64_pkg::WORD_BYTES; i++) begin
         data_m[8*i +: 8] = (fh64_pkg::NB_W'(i) < nb) ? req_word_data[8*i +: 8] : 8'h00;
      end
   end

   always_comb begin
      q_push           = accept & live;
      q_wdata.first    = req_first_word;
      q_wdata.last     = req_last_word;
      q_wdata.has_data = (nb != '0);
      q_wdata.data     = data_m;
      q_wdata.len      = req_total_length[fh64_pkg::LEN_BITS-1:0];
      in_msg_in        = in_msg_ff;
      if (accept && live) begin
         in_msg_in = ~req_last_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_msg_ff <= 1'b0;
      end else begin
         in_msg_ff <= in_msg_in;
      end
   end

endmodule

@@ src/fh64_queue.sv @@
// short fifo of classified words between front end and sequencer
// uses fh64_pkg
`timescale 1ns / 1ps

module fh64_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_push,
   input  fh64_pkg::cmd_type q_wdata,
   output logic              q_full,
   input  logic              q_pop,
   output logic              q_valid,
   output fh64_pkg::cmd_type q_rdata
);

   fh64_pkg::cmd_type                 mem_ff [fh64_pkg::Q_DEPTH];
   logic [fh64_pkg::Q_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [fh64_pkg::Q_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [fh64_pkg::Q_CNT_W-1:0]      cnt_ff, cnt_in;
   logic                              do_push, do_pop;

   assign q_full  = (cnt_ff == fh64_pkg::Q_CNT_W'(fh64_pkg::Q_DEPTH));
   assign q_valid = (cnt_ff != '0);
   assign q_rdata = mem_ff[rd_ptr_ff];
   assign do_push = q_push & ~q_full;
   assign do_pop  = q_pop & q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == fh64_pkg::Q_PTR_W'(fh64_pkg::Q_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + fh64_pkg::Q_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == fh64_pkg::Q_PTR_W'(fh64_pkg::Q_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + fh64_pkg::Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + fh64_pkg::Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - fh64_pkg::Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= q_wdata;
      end
   end

endmodule

@@ src/fh64_back.sv @@
// sequencer: seeds, mixes and folds each queued word through the shared
// multiplier, finishes the hash and holds it in the output register; uses fh64_pkg
`timescale 1ns / 1ps

module fh64_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  fh64_pkg::cmd_type     q_rdata,
   output logic                  q_pop,
   input  logic [63:0]           hash_seed,
   output fh64_pkg::mul_req_type mul_req,
   input  logic                  mul_done,
   input  logic [63:0]           mul_p,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [63:0]           rsp_hash_value
);

   fh64_pkg::back_state_type state_ff, state_in;
   fh64_pkg::cmd_type        cmd_ff, cmd_in;
   logic [63:0]              hash_ff, hash_in;
   logic                     out_valid_ff, out_valid_in;
   logic [63:0]              out_data_ff, out_data_in;
   logic                     out_load;
   logic [63:0]              seeded;
   logic [63:0]              mixed;

   assign seeded = hash_seed ^ mul_p;
   assign mixed  = fh64_pkg::xs_b(mul_p);

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      hash_in  = hash_ff;
      q_pop    = 1'b0;
      out_load = 1'b0;
      mul_req  = '0;
      unique case (state_ff)
         fh64_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_rdata;
               state_in = fh64_pkg::ST_START;
            end
         end
         fh64_pkg::ST_START: begin
            priority if (cmd_ff.first) begin
               mul_req  = '{1'b1, 64'(cmd_ff.len), fh64_pkg::HASH_MUL};
               state_in = fh64_pkg::ST_SEED;
            end else if (cmd_ff.has_data) begin
               mul_req  = '{1'b1, fh64_pkg::xs_a(cmd_ff.data), fh64_pkg::MIX_MUL};
               state_in = fh64_pkg::ST_MIX;
            end else if (cmd_ff.last) begin
               mul_req  = '{1'b1, fh64_pkg::xs_a(hash_ff), fh64_pkg::MIX_MUL};
               state_in = fh64_pkg::ST_FINAL;
            end else begin
               state_in = fh64_pkg::ST_IDLE;
            end
         end
         fh64_pkg::ST_SEED: begin
            if (mul_done) begin
               hash_in = seeded;
               priority if (cmd_ff.has_data) begin
                  mul_req  = '{1'b1, fh64_pkg::xs_a(cmd_ff.data), fh64_pkg::MIX_MUL};
                  state_in = fh64_pkg::ST_MIX;
               end else if (cmd_ff.last) begin
                  mul_req  = '{1'b1, fh64_pkg::xs_a(seeded), fh64_pkg::MIX_MUL};
                  state_in = fh64_pkg::ST_FINAL;
               end else begin
                  state_in = fh64_pkg::ST_IDLE;
               end
            end
         end
         fh64_pkg::ST_MIX: begin
            if (mul_done) begin
               mul_req  = '{1'b1, hash_ff ^ mixed, fh64_pkg::HASH_MUL};
               state_in = fh64_pkg::ST_FOLD;
            end
         end
         fh64_pkg::ST_FOLD: begin
            if (mul_done) begin
               hash_in = mul_p;
               if (cmd_ff.last) begin
                  mul_req  = '{1'b1, fh64_pkg::xs_a(mul_p), fh64_pkg::MIX_MUL};
                  state_in = fh64_pkg::ST_FINAL;
               end else begin
                  state_in = fh64_pkg::ST_IDLE;
               end
            end
         end
         fh64_pkg::ST_FINAL: begin
            if (mul_done) begin
               state_in = fh64_pkg::ST_OUT;
            end
         end
         fh64_pkg::ST_OUT: begin
            // product stays in the multiplier until the output register frees up
            if (!out_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = fh64_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fh64_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff & rsp_stall;
      out_data_in  = out_data_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
         out_data_in  = mixed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fh64_pkg::ST_IDLE;
         hash_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_hash_value = out_data_ff;

endmodule

@@ src/fasthash64_stream.sv @@
// fasthash64 over 64-bit words: each data word goes through the sequencer's shared
// multiplier (three 32x32 partial products per 64-bit multiply, two multiplies per
// word); a first word adds a seeding multiply, a last word a final mix and the output
// register load. a 2-word queue lets the front end take words while the sequencer works.
// synchronous active-high reset clears control state and the hash, seed goes to 0xA16231A7.
`timescale 1ns / 1ps

module fasthash64_stream (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [63:0]                   req_word_data,
   input  logic [fh64_pkg::NB_W-1:0]     req_valid_bytes,
   input  logic                          req_first_word,
   input  logic                          req_last_word,
   input  logic [15:0]                   req_total_length,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [63:0]                   rsp_hash_value,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [fh64_pkg::ADDR_W-1:0]   paddr,
   input  logic [63:0]                   pwdata,
   output logic [63:0]                   prdata,
   output logic                          pready
);

   logic [63:0]           seed_ff, seed_in;
   logic                  q_push, q_full, q_pop, q_valid;
   fh64_pkg::cmd_type     q_wdata, q_rdata;
   fh64_pkg::mul_req_type mul_req;
   logic                  mul_done;
   logic [63:0]           mul_p;
   logic                  seed_hit;

   assign pready   = 1'b1;
   assign seed_hit = (paddr == fh64_pkg::ADDR_HASH_SEED);
   assign prdata   = seed_hit ? seed_ff : 64'h0;

   always_comb begin
      seed_in = seed_ff;
      if (psel && penable && pwrite && seed_hit) begin
         seed_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= fh64_pkg::SEED_RESET;
      end else begin
         seed_ff <= seed_in;
      end
   end

   fh64_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_word_data    (req_word_data),
      .req_valid_bytes  (req_valid_bytes),
      .req_first_word   (req_first_word),
      .req_last_word    (req_last_word),
      .req_total_length (req_total_length),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_wdata          (q_wdata)
   );

   fh64_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_wdata (q_wdata),
      .q_full  (q_full),
      .q_pop   (q_pop),
      .q_valid (q_valid),
      .q_rdata (q_rdata)
   );

   fh64_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .mul_req  (mul_req),
      .mul_done (mul_done),
      .mul_p    (mul_p)
   );

   fh64_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_rdata        (q_rdata),
      .q_pop          (q_pop),
      .hash_seed      (seed_ff),
      .mul_req        (mul_req),
      .mul_done       (mul_done),
      .mul_p          (mul_p),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

@@ src/fh64_checker.sv @@
// port-level checks for fasthash64_stream, attached by bind
// uses assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fh64_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [63:0]                   rsp_hash_value,
   input logic                          pready
);

   // no hash word may come out of reset
   `ASSERT_CLK(a_no_rsp_after_reset, $past(reset) |-> !rsp_valid, "result word right after reset")

   `ASSERT_ALL(a_pready_high, pready, "pready dropped")

   `ASSERT_CLK(a_rsp_held, rsp_valid && rsp_stall |=> rsp_valid, "result word withdrawn while stalled")

   `ASSERT_CLK(a_rsp_stable, rsp_valid && rsp_stall |=> $stable(rsp_hash_value), "stalled hash changed")

endmodule

bind fasthash64_stream fh64_checker u_fh64_checker (.*);

@@ tb/fasthash64_stream_test.sv @@
// self-checking testbench for fasthash64_stream: directed table, then random messages
// checked against an in-bench fasthash64 predictor; needs fh64_pkg and the block's RTL
`timescale 1ns / 1ps

module fasthash64_stream_test;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 100;
   localparam int PHASE_WORDS    = 290;
   localparam int NUM_PHASES     = 5;

   typedef enum bit {CHK_PREDICT, CHK_NO_HASH} row_chk_type;

   typedef struct {
      logic [63:0] data;
      logic [3:0]  nb;
      bit          is_first;
      bit          is_last;
      logic [15:0] len;
      row_chk_type chk;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_word_data = '0;
   logic [3:0]  req_valid_bytes = '0;
   logic        req_first_word = 1'b0;
   logic        req_last_word = 1'b0;
   logic [15:0] req_total_length = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_hash_value;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [fh64_pkg::ADDR_W-1:0] paddr = '0;
   logic [63:0]       pwdata = '0;
   logic [63:0]       prdata;
   logic              pready;

   // predictor state
   logic [63:0] seed_reg;
   logic [63:0] run_hash;
   bit          msg_open;

   logic [63:0] hash_q[$];
   int errors = 0;
   int words_taken = 0;
   int hashes_checked = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int idle_cycles = 0;

   stim_row_type dir_tab [22] = '{
      '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0, 1'b1, 16'hFFFF, CHK_NO_HASH},
      '{64'h0123_4567_89AB_CDEF, 4'd8, 1'b0, 1'b0, 16'h0000, CHK_NO_HASH},
      '{64'h0000_0000_0000_0000, 4'd0, 1'b1, 1'b1, 16'h0000, CHK_PREDICT},
      '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 1'b1, 16'h0008, CHK_PREDICT},
      '{64'h0000_0000_0000_0000, 4'd8, 1'b1, 1'b1, 16'hFFFF, CHK_PREDICT},
      '{64'h0807_0605_0403_0201, 4'd8, 1'b1, 1'b0, 16'h000B, CHK_PREDICT},
      '{64'hFFFF_FFFF_FFFF_FFFF, 4'd3, 1'b0, 1'b1, 16'h000B, CHK_PREDICT},
      '{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1, 1'b1, 16'h0008, CHK_PREDICT},
      '{64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 1'b1, 1'b1, 16'h0008, CHK_PREDICT},
      '{64'hA5A5_A5A5_A5A5_A5A5, 4'd5, 1'b1, 1'b0, 16'h000F, CHK_PREDICT},
      '{64'h5A5A_5A5A_5A5A_5A5A, 4'd2, 1'b0, 1'b0, 16'h0000, CHK_PREDICT},
      '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0, 1'b1, 16'h0000, CHK_PREDICT},
      '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 1'b0, 16'h0009, CHK_PREDICT},
      '{64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0, 1'b0, 16'h0000, CHK_PREDICT},
      '{64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 1'b0, 1'b1, 16'h0000, CHK_PREDICT},
      '{64'h1111_1111_1111_1111, 4'd8, 1'b1, 1'b0, 16'h0010, CHK_PREDICT},
      '{64'h2222_2222_2222_2222, 4'd4, 1'b1, 1'b1, 16'h0004, CHK_PREDICT},
      '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 1'b0, 16'h0008, CHK_PREDICT},
      '{64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0, 1'b1, 16'h0000, CHK_PREDICT},
      '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0, 1'b1, 16'h0000, CHK_NO_HASH},
      '{64'hDEAD_BEEF_CAFE_F00D, 4'd8, 1'b1, 1'b1, 16'h1234, CHK_PREDICT},
      '{64'hFFFF_FFFF_FFFF_FFFF, 4'd7, 1'b1, 1'b1, 16'h0007, CHK_PREDICT}
   };

   fasthash64_stream dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_word_data(req_word_data), .req_valid_bytes(req_valid_bytes),
      .req_first_word(req_first_word), .req_last_word(req_last_word),
      .req_total_length(req_total_length),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_hash_value(rsp_hash_value),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] fh_mix(input logic [63:0] x);
      logic [63:0] y;
      y = x ^ (x >> fh64_pkg::SHIFT_A);
      y = y * fh64_pkg::MIX_MUL;
      return y ^ (y >> fh64_pkg::SHIFT_B);
   endfunction

   // advances the predictor by one word; returns 1 when a hash comes out
   function automatic bit fh_predict(input logic [63:0] data, input logic [3:0] nb,
                                     input bit is_first, input bit is_last,
                                     input logic [15:0] len, output logic [63:0] hv,
                                     output bit took);
      logic [63:0] masked;
      int n;
      hv = '0;
      took = 1'b0;
      if (is_first) begin
         run_hash = seed_reg ^ ({48'd0, len} * fh64_pkg::HASH_MUL);
         msg_open = 1'b1;
      end
      if (!msg_open) return 1'b0;
      took = 1'b1;
      n = (nb > 4'd8) ? 8 : int'(nb);
      if (n != 0) begin
         masked = (n < 8) ? (data & ((64'd1 << (8 * n)) - 64'd1)) : data;
         run_hash = (run_hash ^ fh_mix(masked)) * fh64_pkg::HASH_MUL;
      end
      if (is_last) begin
         hv = fh_mix(run_hash);
         msg_open = 1'b0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic drive_word(input logic [63:0] data, input logic [3:0] nb,
                             input bit is_first, input bit is_last,
                             input logic [15:0] len, input row_chk_type chk);
      int gaps;
      bit got;
      bit took;
      logic [63:0] hv;
      gaps = 0;
      if (send_idle_pct != 0)
         while ($urandom_range(99) < send_idle_pct) gaps++;
      if (gaps > 0) begin
         req_valid <= 1'b0;
         repeat (gaps) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_word_data    <= data;
      req_valid_bytes  <= nb;
      req_first_word   <= is_first;
      req_last_word    <= is_last;
      req_total_length <= len;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      got = fh_predict(data, nb, is_first, is_last, len, hv, took);
      if (took) words_taken++;
      if (got && chk == CHK_PREDICT) hash_q.push_back(hv);
   endtask

   task automatic csr_access(input bit wr, input logic [63:0] wdata,
                             output logic [63:0] rdata);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= fh64_pkg::ADDR_HASH_SEED;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (wr) seed_reg = wdata;
   endtask

   task automatic check_seed(input logic [63:0] want);
      logic [63:0] rd;
      csr_access(1'b0, '0, rd);
      if (rd !== want) begin
         $display("%0t: seed readback mismatch, expected %h actual %h", $time, want, rd);
         errors++;
      end
   endtask

   // one message of random content; now and then a short middle word or a cut-off end
   task automatic send_message();
      int n;
      int last_nb;
      logic [3:0] nb;
      logic [15:0] len;
      bit cut;
      n = ($urandom_range(99) < 85) ? $urandom_range(1, 3) : $urandom_range(4, 12);
      last_nb = ($urandom_range(99) < 3) ? $urandom_range(9, 15) : $urandom_range(0, 8);
      cut = $urandom_range(99) < 6;
      len = 16'(8 * (n - 1) + ((last_nb > 8) ? 8 : last_nb));
      if ($urandom_range(99) < 15) len = 16'($urandom_range(0, 65535));
      for (int k = 0; k < n; k++) begin
         nb = (k == n - 1) ? 4'(last_nb) : 4'd8;
         if (k != n - 1 && $urandom_range(99) < 5) nb = 4'($urandom_range(0, 15));
         if (cut && k == n - 1) break;
         drive_word({$urandom, $urandom}, nb, k == 0, k == n - 1,
                    (k == 0) ? len : 16'($urandom), CHK_PREDICT);
      end
   endtask

   // receiver back-pressure
   always @(posedge clock)
      rsp_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (hash_q.size() == 0) begin
            $display("%0t: unexpected hash, expected none actual %h", $time, rsp_hash_value);
            errors++;
         end else begin
            if (rsp_hash_value !== hash_q[0]) begin
               $display("%0t: hash mismatch, expected %h actual %h",
                        $time, hash_q[0], rsp_hash_value);
               errors++;
            end
            hash_q.pop_front();
            hashes_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("** fasthash64_stream: FAILED **");
         $finish;
      end
   end

   initial begin
      logic [63:0] seeds [NUM_PHASES];
      logic [63:0] rd;
      seeds[0] = 64'h0000_0000_A162_31A7;
      seeds[1] = 64'h0000_0000_0000_0000;
      seeds[2] = 64'hFFFF_FFFF_FFFF_FFFF;
      seeds[3] = {$urandom, $urandom};
      seeds[4] = 64'h8000_0000_0000_0001;
      seed_reg = 64'h0000_0000_A162_31A7;
      run_hash = '0;
      msg_open = 1'b0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_seed(64'h0000_0000_A162_31A7);

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p > 0) begin
            // let the block drain before touching the seed
            req_valid <= 1'b0;
            while (hash_q.size() != 0) @(posedge clock);
            repeat (SETTLE_CYCLES) @(posedge clock);
            csr_access(1'b1, seeds[p], rd);
            check_seed(seeds[p]);
         end
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
            default: begin send_idle_pct = 16; recv_stall_pct = 16; end
         endcase
         if (p == 0)
            foreach (dir_tab[i])
               drive_word(dir_tab[i].data, dir_tab[i].nb, dir_tab[i].is_first,
                          dir_tab[i].is_last, dir_tab[i].len, dir_tab[i].chk);
         while (words_taken < PHASE_WORDS * (p + 1)) begin
            if ($urandom_range(99) < 12)
               drive_word({$urandom, $urandom}, 4'($urandom_range(0, 15)),
                          1'($urandom_range(1)), 1'($urandom_range(1)),
                          16'($urandom_range(0, 65535)), CHK_PREDICT);
            else
               send_message();
         end
      end

      req_valid <= 1'b0;
      while (hash_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d words in messages, %0d hashes compared", words_taken,
               hashes_checked);
      $display("across %0d seed settings and four idle/stall mixes", NUM_PHASES);
      if (errors == 0)
         $display("** fasthash64_stream: PASSED **");
      else
         $display("** fasthash64_stream: FAILED **");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+src
src/fh64_pkg.sv
src/fh64_mul.sv
src/fh64_front.sv
src/fh64_queue.sv
src/fh64_back.sv
src/fasthash64_stream.sv
src/fh64_checker.sv
tb/fasthash64_stream_test.sv
